### hdl/mcrqs_pkg.sv
// Shared types and constants of the multi-CPU ready queue scheduler.
package mcrqs_pkg;

    // Field widths fixed by the item format.
    localparam int CMD_W   = 3;
    localparam int CPU_W   = 4;
    localparam int PID_W   = 5;
    localparam int PRIO_W  = 4;
    localparam int SLICE_W = 16;
    localparam int ACTIVE_W = 5;
    localparam int CFG_IDX_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PREEMPT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TERMINATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAKE_UP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IDLE_REQ  = 3'd4;

    // Result action codes.
    localparam logic ACT_DISPATCH = 1'b0;
    localparam logic ACT_PREEMPT  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS   = 2'd2;

    // One ready queue entry, also the running-process record of a CPU.
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Update controls for the CPU table.
    typedef struct packed {
        logic busy_clr;
        logic busy_set;
        logic wr_en;
    } cpu_ctl_t;

endpackage

### hdl/mcrqs_qmem.sv
// Ready queue storage: one write port and one registered read port.
module mcrqs_qmem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  mcrqs_pkg::entry_t    wdata,
    input  logic [AW-1:0]        raddr,
    output mcrqs_pkg::entry_t    rdata
);

    mcrqs_pkg::entry_t mem_reg [DEPTH];
    mcrqs_pkg::entry_t rdata_reg;

    // Write and read in the same clocked block; read data is registered and appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mcrqs_ctbl.sv
// CPU table: busy flags in flip-flops and running-process records in a memory.
module mcrqs_ctbl #(
    parameter int NCPU = 16,
    parameter int AW   = 4,
    parameter int NW   = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mcrqs_pkg::cpu_ctl_t   ctl,
    input  logic [AW-1:0]         addr,
    input  mcrqs_pkg::entry_t     wdata,
    input  logic [AW-1:0]         raddr,
    output mcrqs_pkg::entry_t     rdata,
    input  logic [AW-1:0]         qaddr,
    output logic                  busy_q,
    input  logic [NW-1:0]         scan_n,
    output logic                  idle_any
);

    logic [NCPU-1:0]   busy_reg;
    mcrqs_pkg::entry_t mem_reg [NCPU];
    mcrqs_pkg::entry_t rdata_reg;

    // Busy flags are cleared at reset, so the record of an idle CPU is never used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (ctl.busy_clr)
        begin
            busy_reg[addr] <= 1'b0;
        end
        else if (ctl.busy_set)
        begin
            busy_reg[addr] <= 1'b1;
        end
    end

    // Running-process records.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata  = rdata_reg;
    assign busy_q = busy_reg[qaddr];

    // Any idle CPU among the first scan_n means a wake-up preempts nobody.
    always_comb
    begin
        idle_any = 1'b0;
        for (int i = 0; i < NCPU; i++)
        begin
            if ((i < int'(scan_n)) && !busy_reg[i])
            begin
                idle_any = 1'b1;
            end
        end
    end

endmodule

### hdl/multi_cpu_ready_queue_scheduler.sv
// Top level of the multi-CPU ready queue scheduler: sequencer, registers and memories.
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+---------------------------
//  command  | command, cpu_id, process_id, priority_req        | start && !busy
//  result   | action, target_cpu, run_valid, run_process,      | done, one cycle, no stall
//           | slice_out                                        |
//  config   | cfg_index, cfg_data                              | cfg_valid && cfg_ready
//
// A wake-up queues the process and, in priority mode when the first n CPUs are all busy,
// scans them for a victim (one CPU record read per cycle from the CPU table memory).
// A dispatch scans the queue, then moves up the entries behind the pick; the scan
// reads one entry in FIFO mode and the whole queue in priority mode; the single read
// port of the queue memory sets this. An empty queue gives the idle result.
// Preempt of a busy CPU first reads its record. Ignored items give no result.
// Reset is asynchronous and active low; the queue and CPU records need no clearing pass.
// The receiver cannot stall: each result shows on done for exactly one cycle.
module multi_cpu_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH     = 32,
    parameter int MAX_CPUS        = 16,
    parameter int PRIORITY_LEVELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mcrqs_pkg::CMD_W-1:0]         command,
    input  logic [mcrqs_pkg::CPU_W-1:0]         cpu_id,
    input  logic [mcrqs_pkg::PID_W-1:0]         process_id,
    input  logic [mcrqs_pkg::PRIO_W-1:0]        priority_req,
    output logic                                done,
    output logic                                action,
    output logic [mcrqs_pkg::CPU_W-1:0]         target_cpu,
    output logic                                run_valid,
    output logic [mcrqs_pkg::PID_W-1:0]         run_process,
    output logic [mcrqs_pkg::SLICE_W-1:0]       slice_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcrqs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcrqs_pkg::SLICE_W-1:0]       cfg_data
);

    localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CAW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SNW  = $clog2(MAX_CPUS + 1);
    localparam int MAXN = (QUEUE_DEPTH > MAX_CPUS) ? QUEUE_DEPTH : MAX_CPUS;
    localparam int IW   = $clog2(MAXN + 1);
    localparam logic [mcrqs_pkg::PRIO_W-1:0] PRIO_MAX =
        mcrqs_pkg::PRIO_W'(PRIORITY_LEVELS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDCPU  = 3'd1;
    localparam logic [2:0] ST_DISP   = 3'd2;
    localparam logic [2:0] ST_QSCAN  = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_WSCAN  = 3'd6;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic                                mode_reg;
    logic [mcrqs_pkg::SLICE_W-1:0]       slice_ticks_reg;
    logic [mcrqs_pkg::ACTIVE_W-1:0]      active_reg;

    // Working registers.
    logic [CW-1:0]                       count_reg, count_next;
    logic [CAW-1:0]                      cpu_reg, cpu_next;
    logic [mcrqs_pkg::PRIO_W-1:0]        prio_reg, prio_next;
    logic [IW-1:0]                       idx_reg, idx_next;
    logic [IW-1:0]                       limit_reg, limit_next;
    logic                                pend_reg, pend_next;
    logic [IW-1:0]                       pend_idx_reg, pend_idx_next;
    logic                                have_reg, have_next;
    logic [IW-1:0]                       best_idx_reg, best_idx_next;
    mcrqs_pkg::entry_t                   best_ent_reg, best_ent_next;

    // Result registers.
    logic                                done_reg, done_next;
    logic                                action_reg, action_next;
    logic [mcrqs_pkg::CPU_W-1:0]         target_reg, target_next;
    logic                                run_valid_reg, run_valid_next;
    logic [mcrqs_pkg::PID_W-1:0]         run_process_reg, run_process_next;
    logic [mcrqs_pkg::SLICE_W-1:0]       slice_out_reg, slice_out_next;

    // Memory ports.
    logic                                q_we;
    logic [QAW-1:0]                      q_waddr;
    mcrqs_pkg::entry_t                   q_wdata;
    logic [QAW-1:0]                      q_raddr;
    mcrqs_pkg::entry_t                   q_rdata;
    mcrqs_pkg::cpu_ctl_t                 c_ctl;
    logic [CAW-1:0]                      c_addr;
    logic [CAW-1:0]                      c_raddr;
    mcrqs_pkg::entry_t                   c_rdata;
    logic                                busy_q;
    logic                                idle_any;

    logic                                cpu_ok;
    logic                                q_full;
    logic                                issue;
    logic [mcrqs_pkg::PRIO_W-1:0]        prio_in;
    logic [SNW-1:0]                      scan_n;

    mcrqs_qmem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (QAW)
    ) u_qmem (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mcrqs_ctbl #(
        .NCPU (MAX_CPUS),
        .AW   (CAW),
        .NW   (SNW)
    ) u_ctbl (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (c_ctl),
        .addr     (c_addr),
        .wdata    (best_ent_reg),
        .raddr    (c_raddr),
        .rdata    (c_rdata),
        .qaddr    (CAW'(cpu_id)),
        .busy_q   (busy_q),
        .scan_n   (scan_n),
        .idle_any (idle_any)
    );

    // Decoded input conditions.
    assign cpu_ok  = (32'(cpu_id) < MAX_CPUS);
    assign prio_in = (32'(priority_req) > PRIORITY_LEVELS - 1) ? PRIO_MAX : priority_req;
    assign scan_n  = (32'(active_reg) > MAX_CPUS) ? SNW'(MAX_CPUS) : SNW'(active_reg);
    assign q_full  = !(32'(count_reg) < QUEUE_DEPTH);
    assign issue   = (idx_reg < limit_reg);

    // Scan and shift addresses come from the shared index counter.
    assign q_raddr = idx_reg[QAW-1:0];
    assign c_raddr = (state_reg == ST_IDLE) ? CAW'(cpu_id) : idx_reg[CAW-1:0];

    // Sequencer. Each phase issues one read per cycle and consumes the registered read
    // data; shift writes always land two entries below the read address.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cpu_next         = cpu_reg;
        prio_next        = prio_reg;
        idx_next         = idx_reg;
        limit_next       = limit_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        have_next        = have_reg;
        best_idx_next    = best_idx_reg;
        best_ent_next    = best_ent_reg;
        done_next        = 1'b0;
        action_next      = action_reg;
        target_next      = target_reg;
        run_valid_next   = run_valid_reg;
        run_process_next = run_process_reg;
        slice_out_next   = slice_out_reg;
        q_we             = 1'b0;
        q_waddr          = count_reg[QAW-1:0];
        q_wdata          = '{pid: process_id, prio: prio_in};
        c_ctl            = '0;
        c_addr           = cpu_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cpu_next  = CAW'(cpu_id);
                    prio_next = prio_in;
                    c_addr    = CAW'(cpu_id);
                    if (command == mcrqs_pkg::CMD_WAKE_UP)
                    begin
                        // Queue the woken process, then look for a victim CPU.
                        if (!q_full)
                        begin
                            q_we       = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        if (mode_reg && (scan_n != '0) && !idle_any)
                        begin
                            idx_next   = '0;
                            limit_next = IW'(scan_n);
                            pend_next  = 1'b0;
                            have_next  = 1'b0;
                            state_next = ST_WSCAN;
                        end
                    end
                    else if (cpu_ok)
                    begin
                        if ((command == mcrqs_pkg::CMD_PREEMPT) ||
                            (command == mcrqs_pkg::CMD_YIELD) ||
                            (command == mcrqs_pkg::CMD_TERMINATE))
                        begin
                            if ((command == mcrqs_pkg::CMD_PREEMPT) && busy_q)
                            begin
                                state_next = ST_RDCPU;
                            end
                            else
                            begin
                                c_ctl.busy_clr = 1'b1;
                                state_next     = ST_DISP;
                            end
                        end
                        else if ((command == mcrqs_pkg::CMD_IDLE_REQ) &&
                                 (count_reg != '0) && !busy_q)
                        begin
                            state_next = ST_DISP;
                        end
                    end
                end
            end

            ST_RDCPU:
            begin
                // Put the preempted process back at the tail.
                if (!q_full)
                begin
                    q_we       = 1'b1;
                    q_wdata    = c_rdata;
                    count_next = count_reg + CW'(1);
                end
                c_ctl.busy_clr = 1'b1;
                state_next     = ST_DISP;
            end

            ST_DISP:
            begin
                if (count_reg == '0)
                begin
                    // Nothing ready: the CPU goes idle.
                    done_next        = 1'b1;
                    action_next      = mcrqs_pkg::ACT_DISPATCH;
                    target_next      = mcrqs_pkg::CPU_W'(cpu_reg);
                    run_valid_next   = 1'b0;
                    run_process_next = '0;
                    slice_out_next   = '0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    limit_next = mode_reg ? IW'(count_reg) : IW'(1);
                    pend_next  = 1'b0;
                    have_next  = 1'b0;
                    state_next = ST_QSCAN;
                end
            end

            ST_QSCAN:
            begin
                // Keep the first entry of highest priority.
                if (pend_reg && (!have_reg || (q_rdata.prio > best_ent_reg.prio)))
                begin
                    best_ent_next = q_rdata;
                    best_idx_next = pend_idx_reg;
                    have_next     = 1'b1;
                end
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + IW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        idx_next   = best_idx_reg + IW'(1);
                        limit_next = IW'(count_reg);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Close the gap left by the picked entry.
                if (pend_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = QAW'(pend_idx_reg - IW'(1));
                    q_wdata = q_rdata;
                end
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + IW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                // Hand the picked process to the CPU.
                count_next       = count_reg - CW'(1);
                c_ctl.busy_set   = 1'b1;
                c_ctl.wr_en      = 1'b1;
                done_next        = 1'b1;
                action_next      = mcrqs_pkg::ACT_DISPATCH;
                target_next      = mcrqs_pkg::CPU_W'(cpu_reg);
                run_valid_next   = 1'b1;
                run_process_next = best_ent_reg.pid;
                slice_out_next   = slice_ticks_reg;
                state_next       = ST_IDLE;
            end

            ST_WSCAN:
            begin
                // Find the first CPU holding the strictly lowest priority.
                if (pend_reg && (!have_reg || (c_rdata.prio < best_ent_reg.prio)))
                begin
                    best_ent_next = c_rdata;
                    best_idx_next = pend_idx_reg;
                    have_next     = 1'b1;
                end
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + IW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (have_reg && (best_ent_reg.prio < prio_reg))
                        begin
                            done_next        = 1'b1;
                            action_next      = mcrqs_pkg::ACT_PREEMPT;
                            target_next      = mcrqs_pkg::CPU_W'(best_idx_reg);
                            run_valid_next   = 1'b0;
                            run_process_next = '0;
                            slice_out_next   = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            have_reg  <= have_next;
            done_reg  <= done_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            slice_ticks_reg <= '0;
            active_reg      <= mcrqs_pkg::ACTIVE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mcrqs_pkg::CFG_PRIORITY_MODE: mode_reg        <= cfg_data[0];
                mcrqs_pkg::CFG_SLICE_TICKS:   slice_ticks_reg <= cfg_data;
                mcrqs_pkg::CFG_ACTIVE_CPUS:
                    active_reg <= cfg_data[mcrqs_pkg::ACTIVE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cpu_reg         <= cpu_next;
        prio_reg        <= prio_next;
        idx_reg         <= idx_next;
        limit_reg       <= limit_next;
        pend_idx_reg    <= pend_idx_next;
        best_idx_reg    <= best_idx_next;
        best_ent_reg    <= best_ent_next;
        action_reg      <= action_next;
        target_reg      <= target_next;
        run_valid_reg   <= run_valid_next;
        run_process_reg <= run_process_next;
        slice_out_reg   <= slice_out_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign action      = action_reg;
    assign target_cpu  = target_reg;
    assign run_valid   = run_valid_reg;
    assign run_process = run_process_reg;
    assign slice_out   = slice_out_reg;

    // A result only follows an idle dispatch, a finished dispatch or a wake-up scan.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (($past(state_reg) == ST_DISP) || ($past(state_reg) == ST_FINISH) ||
                      ($past(state_reg) == ST_WSCAN)))
        else $error("result strobe without a producing state");

    // A forced preempt is only named in priority mode.
    a_preempt_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (action_reg == mcrqs_pkg::ACT_PREEMPT)) |-> mode_reg)
        else $error("forced preempt outside priority mode");

    // Finishing a dispatch removes exactly one queue entry.
    a_finish_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("queue count not reduced on dispatch");

    // The shift never reads the entry it writes in the same cycle.
    a_shift_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && pend_reg && issue) |-> (q_waddr != q_raddr))
        else $error("queue shift read and write collide");

endmodule
